[sv/hcl_pkg.sv]
package hcl_pkg;

  // Key text length, "content-length:"
  localparam int unsigned KEY_LEN = 15;

  // Largest value that can still take one more decimal digit
  localparam logic [63:0] VALUE_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF - 64'd9) / 64'd10;

  // ASCII codes used by the scanner
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  // Input beat: one header byte and its end mark
  typedef struct packed {
    logic [7:0] header_byte;
    logic       is_last;
  } in_t;

  // Result beat
  typedef struct packed {
    logic        found;
    logic [63:0] length_value;
  } out_t;

  // Lower-case key character at a given position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[sv/http_content_length_scanner_core.sv]
// Content-Length scanner: takes one header byte per beat and, on the beat
// marked is_last, returns one result beat holding found and the parsed
// decimal length (zero when not found). The key is matched case-insensitively
// at the start of the block or after a newline; the first occurrence decides.
// Throughput is one byte per clock unless stalled: each byte passes an input
// register, the scan state and the 64-bit accumulator (times ten plus digit)
// update from it, and the result is loaded into an output register as the
// last byte leaves the input register. Input is stalled only while a result
// waits in the output register and the next block's last byte is behind it.
module http_content_length_scanner_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcl_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hcl_pkg::out_t  out_data
);

  typedef enum logic [2:0] {
    PH_KEY,
    PH_SKIP,
    PH_BLANK,
    PH_DIGITS,
    PH_GOOD,
    PH_BAD
  } phase_t;

  localparam logic [3:0] KEY_LAST = 4'(hcl_pkg::KEY_LEN - 1);

  // Input register
  logic          s1_vld_r;
  hcl_pkg::in_t  s1_data_r;
  logic          s1_adv;

  // Scan state
  phase_t        phase_r, phase_nxt;
  logic [3:0]    key_pos_r, key_pos_nxt;
  logic [63:0]   acc_r, acc_nxt;

  // Output register
  logic          out_vld_r;
  hcl_pkg::out_t out_data_r, out_data_nxt;

  // Stage advance: only a last byte needs room in the output register
  assign s1_adv   = !s1_data_r.is_last || !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Per-byte scan update
  logic [7:0]  b;
  logic [7:0]  lc;
  logic        is_dig;
  logic        over;
  logic [63:0] acc_x10;
  logic [63:0] dig_val;
  logic        ok;

  always_comb begin
    b       = s1_data_r.header_byte;
    lc      = (b >= hcl_pkg::CH_UP_A && b <= hcl_pkg::CH_UP_Z) ? b + 8'd32 : b;
    is_dig  = (b >= hcl_pkg::CH_ZERO) && (b <= hcl_pkg::CH_NINE);
    dig_val = {60'd0, 4'(b - hcl_pkg::CH_ZERO)};
    over    = acc_r > hcl_pkg::VALUE_LIMIT;
    acc_x10 = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0};

    phase_nxt   = phase_r;
    key_pos_nxt = key_pos_r;
    acc_nxt     = acc_r;

    unique case (phase_r)
      PH_KEY: begin
        if (lc == hcl_pkg::key_char(key_pos_r)) begin
          key_pos_nxt = key_pos_r + 4'd1;
          if (key_pos_r == KEY_LAST) begin
            phase_nxt = PH_BLANK;
          end
        end else begin
          key_pos_nxt = 4'd0;
          phase_nxt   = (b == hcl_pkg::CH_NL) ? PH_KEY : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == hcl_pkg::CH_NL) begin
          phase_nxt   = PH_KEY;
          key_pos_nxt = 4'd0;
        end
      end
      PH_BLANK: begin
        if (b == hcl_pkg::CH_SPACE || b == hcl_pkg::CH_TAB) begin
          phase_nxt = PH_BLANK;
        end else if (is_dig) begin
          // First digit: accumulator restarts at this digit
          phase_nxt = PH_DIGITS;
          acc_nxt   = dig_val;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (!is_dig) begin
          phase_nxt = PH_GOOD;
        end else if (over) begin
          phase_nxt = PH_BAD;
        end else begin
          acc_nxt = acc_x10 + dig_val;
        end
      end
      default: begin
        // decided: ignore the rest of the block
      end
    endcase

    ok                        = (phase_nxt == PH_DIGITS) || (phase_nxt == PH_GOOD);
    out_data_nxt.found        = ok;
    out_data_nxt.length_value = ok ? acc_nxt : 64'd0;
  end

  // State register; a last byte returns the scanner to line start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_KEY;
      key_pos_r <= 4'd0;
      acc_r     <= 64'd0;
    end else if (s1_vld_r && s1_adv) begin
      if (s1_data_r.is_last) begin
        phase_r   <= PH_KEY;
        key_pos_r <= 4'd0;
        acc_r     <= 64'd0;
      end else begin
        phase_r   <= phase_nxt;
        key_pos_r <= key_pos_nxt;
        acc_r     <= acc_nxt;
      end
    end
  end

  // Output register
  logic res_load;
  assign res_load = s1_vld_r && s1_adv && s1_data_r.is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Checks
  a_zero_when_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.found |-> out_data_r.length_value == 64'd0)
    else $error("length_value not zero on a not-found result");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> phase_r == PH_KEY && key_pos_r == 4'd0 && acc_r == 64'd0)
    else $error("scanner not back at line start after last byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_vld_r && out_stall)
    else $error("input stalled while output register could take a beat");

  a_key_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_KEY |-> key_pos_r <= KEY_LAST)
    else $error("key position past end of key");

endmodule
